FILE: hdl/rpcl_pkg.sv
// ----------------------------------------------------------------------------
// rpcl_pkg
// Shared types and constants of the RIFF/PNG container locator: signature
// patterns, result kind codes and the result record.
// ----------------------------------------------------------------------------
package rpcl_pkg;

  // Default offset counter width
  localparam int unsigned OFFSET_BITS_DEF = 32;

  // Scan window depth in bytes and number of RIFF size bytes
  localparam int unsigned WIN_BYTES  = 7;
  localparam int unsigned SIZE_BYTES = 4;

  // Result queue depth, a power of two
  localparam int unsigned FIFO_DEPTH = 4;

  // Signatures, first byte in the most significant position
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_PNG  = 32'h8950_4E47;
  localparam logic [63:0] TAG_IEND = 64'h4945_4E44_AE42_6082;

  // Container kind codes
  localparam logic KIND_RIFF = 1'b0;
  localparam logic KIND_PNG  = 1'b1;

  // One located container
  typedef struct packed {
    logic        container_kind;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic        truncated;
    logic        last_result;
  } result_t;

endpackage

FILE: hdl/rpcl_scan.sv
// ----------------------------------------------------------------------------
// rpcl_scan
// Scanner state and per-byte logic: signature window, RIFF size assembly,
// PNG open/close tracking. Produces up to two results per accepted byte.
// ----------------------------------------------------------------------------
module rpcl_scan #(
  parameter int unsigned OFFSET_BITS = rpcl_pkg::OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              byte_fire,
  input  logic [7:0]        data_byte,
  input  logic              end_of_stream,
  output rpcl_pkg::result_t res0,
  output rpcl_pkg::result_t res1,
  output logic [1:0]        res_count
);
  import rpcl_pkg::*;

  localparam int unsigned W     = OFFSET_BITS;
  localparam int unsigned SUMW  = ((W > 32) ? W : 32) + 1;
  localparam int unsigned WIN_W = 8 * WIN_BYTES;

  logic [WIN_W-1:0] window_r, window_nxt;
  logic [2:0]       fill_r, fill_nxt;
  logic [W-1:0]     pos_r, pos_nxt;
  logic [2:0]       left_r, left_nxt;
  logic [W-1:0]     riff_start_r, riff_start_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic             png_open_r, png_open_nxt;
  logic [W-1:0]     png_start_r, png_start_nxt;
  logic             big_endian_r, big_endian_nxt;

  // Offset to field width: zero-extend or keep the low 32 bits
  function automatic logic [31:0] to_field(input logic [W-1:0] v);
    logic [SUMW-1:0] t;
    t = SUMW'(v);
    return t[31:0];
  endfunction

  // Per-byte next state and results
  always_comb begin
    logic [WIN_W+7:0] cur;
    logic [1:0]       lane;
    logic [SUMW-1:0]  sum;
    logic [W-1:0]     riff_end;
    logic             have_a;
    result_t          res_a;
    result_t          res_t;
    logic             have_t;

    window_nxt     = window_r;
    fill_nxt       = fill_r;
    pos_nxt        = pos_r;
    left_nxt       = left_r;
    riff_start_nxt = riff_start_r;
    acc_nxt        = acc_r;
    png_open_nxt   = png_open_r;
    png_start_nxt  = png_start_r;
    big_endian_nxt = cfg_wr_en ? cfg_wr_data : big_endian_r;

    cur      = {window_r, data_byte};
    lane     = 2'(3'(SIZE_BYTES) - left_r);
    have_a   = 1'b0;
    have_t   = 1'b0;
    res_a    = '0;
    res_t    = '0;
    sum      = '0;
    riff_end = '0;
    res0     = '0;
    res1     = '0;
    res_count = 2'd0;

    if (byte_fire) begin
      if (left_r != 3'd0) begin
        // Assemble the RIFF size; these bytes skip the window
        if (big_endian_r) begin
          acc_nxt = {acc_r[23:0], data_byte};
        end else begin
          acc_nxt = acc_r | (32'(data_byte) << {lane, 3'b000});
        end
        left_nxt = left_r - 3'd1;
        if (left_r == 3'd1) begin
          // Saturate start + size at the largest offset
          sum      = SUMW'(riff_start_r) + SUMW'(acc_nxt);
          riff_end = (sum[SUMW-1:W] != '0) ? '1 : sum[W-1:0];
          have_a   = 1'b1;
          res_a.container_kind = KIND_RIFF;
          res_a.start_offset   = to_field(riff_start_r);
          res_a.end_offset     = to_field(riff_end);
          res_a.truncated      = 1'b0;
        end
      end else if (fill_r >= 3'd3 && cur[31:0] == TAG_RIFF) begin
        // RIFF tag: start sizing, flush the window
        riff_start_nxt = pos_r - W'(3);
        acc_nxt        = '0;
        left_nxt       = 3'(SIZE_BYTES);
        window_nxt     = '0;
        fill_nxt       = 3'd0;
      end else begin
        if (png_open_r) begin
          if (fill_r == 3'(WIN_BYTES) && cur == TAG_IEND) begin
            have_a               = 1'b1;
            res_a.container_kind = KIND_PNG;
            res_a.start_offset   = to_field(png_start_r);
            res_a.end_offset     = to_field(pos_r);
            res_a.truncated      = 1'b0;
            png_open_nxt         = 1'b0;
          end
        end else if (fill_r >= 3'd3 && cur[31:0] == TAG_PNG) begin
          png_open_nxt  = 1'b1;
          png_start_nxt = pos_r - W'(3);
        end
        window_nxt = cur[WIN_W-1:0];
        if (fill_r != 3'(WIN_BYTES)) begin
          fill_nxt = fill_r + 3'd1;
        end
      end

      pos_nxt = pos_r + W'(1);

      // Stream end: close an open PNG as truncated, drop everything else
      if (end_of_stream) begin
        if (png_open_nxt) begin
          have_t               = 1'b1;
          res_t.container_kind = KIND_PNG;
          res_t.start_offset   = to_field(png_start_nxt);
          res_t.end_offset     = to_field(pos_r);
          res_t.truncated      = 1'b1;
        end
        window_nxt     = '0;
        fill_nxt       = 3'd0;
        pos_nxt        = '0;
        left_nxt       = 3'd0;
        riff_start_nxt = '0;
        acc_nxt        = '0;
        png_open_nxt   = 1'b0;
        png_start_nxt  = '0;
      end

      // Order the results and mark the final one
      if (have_a && have_t) begin
        res0      = res_a;
        res1      = res_t;
        res1.last_result = 1'b1;
        res_count = 2'd2;
      end else if (have_a) begin
        res0      = res_a;
        res0.last_result = 1'b1;
        res_count = 2'd1;
      end else if (have_t) begin
        res0      = res_t;
        res0.last_result = 1'b1;
        res_count = 2'd1;
      end
    end
  end

  // Hold scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= '0;
      fill_r       <= 3'd0;
      pos_r        <= '0;
      left_r       <= 3'd0;
      riff_start_r <= '0;
      acc_r        <= '0;
      png_open_r   <= 1'b0;
      png_start_r  <= '0;
      big_endian_r <= 1'b0;
    end else begin
      window_r     <= window_nxt;
      fill_r       <= fill_nxt;
      pos_r        <= pos_nxt;
      left_r       <= left_nxt;
      riff_start_r <= riff_start_nxt;
      acc_r        <= acc_nxt;
      png_open_r   <= png_open_nxt;
      png_start_r  <= png_start_nxt;
      big_endian_r <= big_endian_nxt;
    end
  end

endmodule

FILE: hdl/rpcl_out_fifo.sv
// ----------------------------------------------------------------------------
// rpcl_out_fifo
// Small result queue: takes up to two results per cycle, hands out one per
// output transaction. Signals room while at least two slots are free.
// ----------------------------------------------------------------------------
module rpcl_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  rpcl_pkg::result_t push0,
  input  rpcl_pkg::result_t push1,
  input  logic [1:0]        push_count,
  output logic              has_room,
  output logic              out_valid,
  input  logic              out_ready,
  output rpcl_pkg::result_t out_data
);
  import rpcl_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  result_t       mem_r [FIFO_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_r];
  assign has_room  = (count_r <= (PW + 1)'(FIFO_DEPTH - 2));

  // Advance pointers and occupancy
  always_comb begin
    wr_nxt    = wr_r + PW'(push_count);
    rd_nxt    = pop ? rd_r + PW'(1) : rd_r;
    count_nxt = count_r + (PW + 1)'(push_count) - (PW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (push_count == 2'd2) begin
      mem_r[wr_r + PW'(1)] <= push1;
    end
  end

endmodule

FILE: hdl/riff_png_container_locator_unit.sv
// ----------------------------------------------------------------------------
// riff_png_container_locator_unit
// Locates RIFF and PNG containers in a byte stream and reports their offsets.
// ----------------------------------------------------------------------------
// The unit takes one byte per clock cycle while in_tready is high and
// queues each byte's results. A "RIFF" tag and the four size bytes after it
// yield one RIFF result (end = start + size, saturated); a PNG signature and
// its IEND trailer yield one PNG result; a byte marked with in_tlast closes
// an open PNG as truncated and restarts offsets at zero. Signature compare,
// size add and state update all happen in the cycle the byte is accepted;
// results wait in a four-entry queue, and in_tready drops while fewer than
// two queue slots are free, so a stalled output side throttles the input.
// cfg_wr_data selects big-endian RIFF sizes; write it only while idle.
module riff_png_container_locator_unit #(
  parameter int unsigned OFFSET_BITS = rpcl_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // size_big_endian
  // byte input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  input  logic        in_tlast,      // end_of_stream
  // result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,     // [31:0] start_offset, [63:32] end_offset
  output logic [1:0]  out_tuser,     // [0] container_kind, [1] truncated
  output logic        out_tlast      // last_result
);
  import rpcl_pkg::*;

  logic       in_fire;
  result_t    res0;
  result_t    res1;
  logic [1:0] res_count;
  logic       has_room;
  result_t    head;

  assign in_tready = has_room;
  assign in_fire   = in_tvalid && in_tready;

  // Per-byte scanner
  rpcl_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .byte_fire     (in_fire),
    .data_byte     (in_tdata),
    .end_of_stream (in_tlast),
    .res0          (res0),
    .res1          (res1),
    .res_count     (res_count)
  );

  // Result queue
  rpcl_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push0      (res0),
    .push1      (res1),
    .push_count (res_count),
    .has_room   (has_room),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (head)
  );

  // Pack the head result onto the output bus
  assign out_tdata = {head.end_offset, head.start_offset};
  assign out_tuser = {head.truncated, head.container_kind};
  assign out_tlast = head.last_result;

endmodule
